[rtl/rx256_pkg.sv]
// ----------------------------------------------------------------------------
// rx256_pkg
// Shared types, constants and small lookup functions for the RGB to
// 256-colour palette quantiser.
// ----------------------------------------------------------------------------
`default_nettype none

package rx256_pkg;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// cube level per channel, 0..5
	typedef struct packed {
		logic [2:0] r;
		logic [2:0] g;
		logic [2:0] b;
	} cube_lvl_t;

	localparam logic [7:0] BASIC_DIM_ON   = 8'haa;
	localparam logic [7:0] BASIC_DIM_OFF  = 8'h00;
	localparam logic [7:0] BASIC_BRT_ON   = 8'hff;
	localparam logic [7:0] BASIC_BRT_OFF  = 8'h55;
	localparam logic [7:0] BRIGHT_THRESH  = 8'haa;
	localparam logic [7:0] GREY_MAX_LEVEL = 8'h55;
	localparam logic [3:0] BASIC_GREY_IDX = 4'd8;

	localparam logic [7:0] CUBE_BASE  = 8'd16;
	localparam logic [7:0] GREY_BASE  = 8'd232;
	localparam logic [4:0] GREY_K_MAX = 5'd23;
	// sum/30 as (sum * 2185) >> 16, exact for sums up to 765
	localparam logic [11:0] GREY_RECIP = 12'd2185;
	localparam int          GREY_SHIFT = 16;

	// level of one channel: min((2c+42)/85, 5) as threshold count
	function automatic logic [2:0] cube_level(input logic [7:0] c);
		logic [2:0] q;
		begin
			q = 3'd0;
			if (c >= 8'd22)  q = 3'd1;
			if (c >= 8'd64)  q = 3'd2;
			if (c >= 8'd107) q = 3'd3;
			if (c >= 8'd149) q = 3'd4;
			if (c >= 8'd192) q = 3'd5;
			return q;
		end
	endfunction

	// level colour q*85/2
	function automatic logic [7:0] cube_colour(input logic [2:0] q);
		logic [7:0] v;
		begin
			case (q)
				3'd0:    v = 8'd0;
				3'd1:    v = 8'd42;
				3'd2:    v = 8'd85;
				3'd3:    v = 8'd127;
				3'd4:    v = 8'd170;
				3'd5:    v = 8'd212;
				default: v = 8'd0;
			endcase
			return v;
		end
	endfunction

endpackage

`default_nettype wire

[rtl/rx256_pixel_if.sv]
// ----------------------------------------------------------------------------
// rx256_pixel_if
// Valid/ready channel carrying one 8-bit RGB pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rx256_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

[rtl/rx256_index_if.sv]
// ----------------------------------------------------------------------------
// rx256_index_if
// Valid/ready channel carrying one 8-bit palette index.
// ----------------------------------------------------------------------------
`default_nettype none

interface rx256_index_if;
	logic       valid;
	logic       ready;
	logic [7:0] palette_index;

	modport source (output valid, output palette_index, input ready);
	modport sink   (input valid, input palette_index, output ready);
endinterface

`default_nettype wire

[rtl/rx256_cand.sv]
// ----------------------------------------------------------------------------
// rx256_cand
// Candidate front end: basic 16-colour index, cube levels, channel sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rx256_cand (
	input  rx256_pkg::rgb_t      px,
	output logic [3:0]           basic_idx,
	output rx256_pkg::cube_lvl_t lvl,
	output logic [9:0]           sum
);

	logic [7:0] m;
	logic [7:0] half;
	logic [2:0] hue;

	always_comb begin
		m = px.r;
		if (px.g > m) m = px.g;
		if (px.b > m) m = px.b;
		half = {1'b0, m[7:1]};
		hue  = {px.b > half, px.g > half, px.r > half};
		if (hue == 3'b111 && m <= rx256_pkg::GREY_MAX_LEVEL) begin
			basic_idx = rx256_pkg::BASIC_GREY_IDX;
		end else begin
			basic_idx = {m > rx256_pkg::BRIGHT_THRESH, hue};
		end
	end

	assign lvl.r = rx256_pkg::cube_level(px.r);
	assign lvl.g = rx256_pkg::cube_level(px.g);
	assign lvl.b = rx256_pkg::cube_level(px.b);
	assign sum   = {2'b00, px.r} + {2'b00, px.g} + {2'b00, px.b};

endmodule

`default_nettype wire

[rtl/rx256_expand.sv]
// ----------------------------------------------------------------------------
// rx256_expand
// Turns the three candidates into palette indices and their RGB colours.
// ----------------------------------------------------------------------------
`default_nettype none

module rx256_expand (
	input  logic [3:0]           basic_idx,
	input  rx256_pkg::cube_lvl_t lvl,
	input  logic [9:0]           sum,
	output rx256_pkg::rgb_t      basic_rgb,
	output logic [7:0]           cube_idx,
	output rx256_pkg::rgb_t      cube_rgb,
	output logic [7:0]           grey_idx,
	output rx256_pkg::rgb_t      grey_rgb
);

	logic [21:0] prod;
	logic [5:0]  k_raw;
	logic [4:0]  k;
	logic [7:0]  k8;
	logic [7:0]  grey_val;
	logic [7:0]  on_v;
	logic [7:0]  off_v;

	// basic palette: dim half 0x00/0xaa, bright half 0x55/0xff
	always_comb begin
		on_v  = basic_idx[3] ? rx256_pkg::BASIC_BRT_ON  : rx256_pkg::BASIC_DIM_ON;
		off_v = basic_idx[3] ? rx256_pkg::BASIC_BRT_OFF : rx256_pkg::BASIC_DIM_OFF;
		basic_rgb.r = basic_idx[0] ? on_v : off_v;
		basic_rgb.g = basic_idx[1] ? on_v : off_v;
		basic_rgb.b = basic_idx[2] ? on_v : off_v;
	end

	assign cube_idx = rx256_pkg::CUBE_BASE
		+ ({5'd0, lvl.r} << 5) + ({5'd0, lvl.r} << 2)
		+ ({5'd0, lvl.g} << 2) + ({5'd0, lvl.g} << 1)
		+ {5'd0, lvl.b};
	assign cube_rgb.r = rx256_pkg::cube_colour(lvl.r);
	assign cube_rgb.g = rx256_pkg::cube_colour(lvl.g);
	assign cube_rgb.b = rx256_pkg::cube_colour(lvl.b);

	// grey step = min(sum/30, 23)
	assign prod  = {12'd0, sum} * {10'd0, rx256_pkg::GREY_RECIP};
	assign k_raw = prod[rx256_pkg::GREY_SHIFT +: 6];
	assign k     = (k_raw > {1'b0, rx256_pkg::GREY_K_MAX}) ? rx256_pkg::GREY_K_MAX : k_raw[4:0];
	assign k8    = {3'd0, k};
	assign grey_val   = (k8 << 3) + (k8 << 1) + 8'd8;
	assign grey_idx   = rx256_pkg::GREY_BASE + k8;
	assign grey_rgb.r = grey_val;
	assign grey_rgb.g = grey_val;
	assign grey_rgb.b = grey_val;

endmodule

`default_nettype wire

[rtl/rx256_sad.sv]
// ----------------------------------------------------------------------------
// rx256_sad
// Sum of absolute channel differences between pixel and candidate colour.
// ----------------------------------------------------------------------------
`default_nettype none

module rx256_sad (
	input  rx256_pkg::rgb_t px,
	input  rx256_pkg::rgb_t cand,
	output logic [9:0]      score
);

	logic [7:0] dr;
	logic [7:0] dg;
	logic [7:0] db;

	assign dr    = (px.r > cand.r) ? px.r - cand.r : cand.r - px.r;
	assign dg    = (px.g > cand.g) ? px.g - cand.g : cand.g - px.g;
	assign db    = (px.b > cand.b) ? px.b - cand.b : cand.b - px.b;
	assign score = {2'b00, dr} + {2'b00, dg} + {2'b00, db};

endmodule

`default_nettype wire

[rtl/rgb_to_xterm256_quantizer.sv]
// ----------------------------------------------------------------------------
// rgb_to_xterm256_quantizer
// Maps an 8-bit RGB pixel to the nearest index of the 256-colour palette.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  : sink channel, one RGB pixel per transfer (red, green, blue).
//   colour : source channel, one palette_index per pixel, in input order.
//   Five register stages:
//     s1  input pixel register
//     s2  basic index, cube levels, channel sum
//     s3  candidate indices and their RGB colours (grey step multiply here)
//     s4  three absolute-difference scores
//     s5  output register holding the chosen index
//   The output valid rises once a pixel has been registered through s1 to s5;
//   throughput is one pixel per clock while the receiver is ready. Each stage
//   holds its own valid bit and loads whenever it is empty or the next stage
//   is loading, so bubbles collapse while the output is stalled and pixels are
//   still taken until every stage is full. A stalled receiver freezes the full
//   stages; nothing is lost or repeated.
//   Reset clears all valid bits; payload registers are not reset.
//   Ties between candidates keep the earlier one (basic, cube, grey).
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_xterm256_quantizer (
	input  wire          clk,
	input  wire          arst_n,
	rx256_pixel_if.sink  pixel,
	rx256_index_if.source colour
);

	// valid bits per stage
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	// stage payloads
	rx256_pkg::rgb_t      px_s1, px_s2, px_s3;
	logic [3:0]           basic_idx_s2;
	rx256_pkg::cube_lvl_t lvl_s2;
	logic [9:0]           sum_s2;
	logic [7:0]           basic_idx_s3, cube_idx_s3, grey_idx_s3;
	rx256_pkg::rgb_t      basic_rgb_s3, cube_rgb_s3, grey_rgb_s3;
	logic [7:0]           basic_idx_s4, cube_idx_s4, grey_idx_s4;
	logic [9:0]           basic_sc_s4, cube_sc_s4, grey_sc_s4;
	logic [7:0]           index_s5;

	// combinational results between stages
	rx256_pkg::rgb_t      px_in;
	logic [3:0]           basic_idx_c;
	rx256_pkg::cube_lvl_t lvl_c;
	logic [9:0]           sum_c;
	rx256_pkg::rgb_t      basic_rgb_c, cube_rgb_c, grey_rgb_c;
	logic [7:0]           cube_idx_c, grey_idx_c;
	logic [9:0]           basic_sc_c, cube_sc_c, grey_sc_c;
	logic [7:0]           best_c;
	logic [9:0]           best_sc_c;

	// per-stage load enables, rippling back from the output
	assign en_s5 = !v_s5 || colour.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign pixel.ready          = en_s1;
	assign colour.valid         = v_s5;
	assign colour.palette_index = index_s5;

	assign px_in.r = pixel.red;
	assign px_in.g = pixel.green;
	assign px_in.b = pixel.blue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pixel.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: capture the pixel
	always_ff @(posedge clk) begin
		if (en_s1 && pixel.valid) begin
			px_s1 <= px_in;
		end
	end

	// stage 2: candidate front end
	rx256_cand u_cand (
		.px        (px_s1),
		.basic_idx (basic_idx_c),
		.lvl       (lvl_c),
		.sum       (sum_c)
	);

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			px_s2        <= px_s1;
			basic_idx_s2 <= basic_idx_c;
			lvl_s2       <= lvl_c;
			sum_s2       <= sum_c;
		end
	end

	// stage 3: indices and palette colours
	rx256_expand u_expand (
		.basic_idx (basic_idx_s2),
		.lvl       (lvl_s2),
		.sum       (sum_s2),
		.basic_rgb (basic_rgb_c),
		.cube_idx  (cube_idx_c),
		.cube_rgb  (cube_rgb_c),
		.grey_idx  (grey_idx_c),
		.grey_rgb  (grey_rgb_c)
	);

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			px_s3        <= px_s2;
			basic_idx_s3 <= {4'd0, basic_idx_s2};
			basic_rgb_s3 <= basic_rgb_c;
			cube_idx_s3  <= cube_idx_c;
			cube_rgb_s3  <= cube_rgb_c;
			grey_idx_s3  <= grey_idx_c;
			grey_rgb_s3  <= grey_rgb_c;
		end
	end

	// stage 4: score each candidate
	rx256_sad u_sad_basic (.px(px_s3), .cand(basic_rgb_s3), .score(basic_sc_c));
	rx256_sad u_sad_cube  (.px(px_s3), .cand(cube_rgb_s3),  .score(cube_sc_c));
	rx256_sad u_sad_grey  (.px(px_s3), .cand(grey_rgb_s3),  .score(grey_sc_c));

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			basic_idx_s4 <= basic_idx_s3;
			cube_idx_s4  <= cube_idx_s3;
			grey_idx_s4  <= grey_idx_s3;
			basic_sc_s4  <= basic_sc_c;
			cube_sc_s4   <= cube_sc_c;
			grey_sc_s4   <= grey_sc_c;
		end
	end

	// stage 5: pick the lowest score, earlier candidate wins a tie
	always_comb begin
		best_c    = basic_idx_s4;
		best_sc_c = basic_sc_s4;
		if (cube_sc_s4 < best_sc_c) begin
			best_c    = cube_idx_s4;
			best_sc_c = cube_sc_s4;
		end
		if (grey_sc_s4 < best_sc_c) begin
			best_c = grey_idx_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			index_s5 <= best_c;
		end
	end

endmodule

`default_nettype wire

[sim/tb_rgb_to_xterm256_quantizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_xterm256_quantizer
// Drives RGB pixels into the palette quantiser under random source gaps and
// sink stalls and checks each returned palette index against a typed index or
// an in-bench best-of-three search (basic sixteen, 6x6x6 cube, grey ramp).
// ----------------------------------------------------------------------------

module tb_rgb_to_xterm256_quantizer;

	// palette layout
	localparam int BASIC_BRIGHT = 8;    // first bright basic colour, also dim grey
	localparam int CUBE_FIRST   = 16;
	localparam int GREY_FIRST   = 232;
	localparam int GREY_LAST    = 255;

	localparam int RANDOM_PIXELS = 1880;
	localparam int QUIET_TAIL    = 300;  // last transfers with no gaps or stalls
	localparam int DRAIN_CYCLES  = 12;   // pipeline is five deep

	// directed row: typed index only where it is obvious, else predicted
	typedef struct packed {
		logic       typed;
		logic [7:0] index;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pixel_row_t;

	localparam int ROW_COUNT = 24;

	logic clk;
	logic arst_n;

	rx256_pixel_if pixel ();
	rx256_index_if colour ();

	rgb_to_xterm256_quantizer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.colour (colour)
	);

	// indices still owed by the block, oldest first
	logic [7:0] owed_index [$];

	logic idling;
	int   mismatches;
	int   pixels_sent;
	int   indices_seen;
	int   basic_hits;
	int   cube_hits;
	int   grey_hits;
	int   clamped_greys;

	pixel_row_t directed_rows [0:ROW_COUNT-1] = '{
		{1'b1, 8'd0,   8'd0,   8'd0,   8'd0},    // black: basic wins the tie with the cube
		{1'b1, 8'd15,  8'd255, 8'd255, 8'd255},  // white: bright basic, exact
		{1'b1, 8'd1,   8'd170, 8'd0,   8'd0},    // dim basic primaries, exact
		{1'b1, 8'd2,   8'd0,   8'd170, 8'd0},
		{1'b1, 8'd4,   8'd0,   8'd0,   8'd170},
		{1'b1, 8'd8,   8'd85,  8'd85,  8'd85},   // dim grey case, exact
		{1'b1, 8'd9,   8'd255, 8'd85,  8'd85},   // bright red, exact
		{1'b0, 8'd0,   8'd255, 8'd0,   8'd0},
		{1'b0, 8'd0,   8'd0,   8'd255, 8'd0},
		{1'b0, 8'd0,   8'd0,   8'd0,   8'd255},
		{1'b0, 8'd0,   8'd84,  8'd84,  8'd84},   // either side of the dim grey limit
		{1'b0, 8'd0,   8'd86,  8'd86,  8'd86},
		{1'b0, 8'd0,   8'd171, 8'd171, 8'd171},  // just over the bright threshold
		{1'b0, 8'd0,   8'd240, 8'd240, 8'd240},  // sum 720: grey index clamped
		{1'b0, 8'd0,   8'd250, 8'd245, 8'd240},
		{1'b0, 8'd0,   8'd230, 8'd230, 8'd230},  // top of the ramp without clamping
		{1'b0, 8'd0,   8'd8,   8'd8,   8'd8},    // first ramp step
		{1'b0, 8'd0,   8'd21,  8'd22,  8'd63},   // cube level boundaries
		{1'b0, 8'd0,   8'd64,  8'd106, 8'd107},
		{1'b0, 8'd0,   8'd148, 8'd149, 8'd191},
		{1'b0, 8'd0,   8'd192, 8'd1,   8'd128},
		{1'b0, 8'd0,   8'd212, 8'd127, 8'd42},   // exact cube colour
		{1'b0, 8'd0,   8'd170, 8'd170, 8'd0},
		{1'b0, 8'd0,   8'd128, 8'd128, 8'd128}
	};

	// cube level boundaries and level colours, for the near-cube stimulus
	int cube_anchor [0:16] = '{0, 21, 22, 42, 63, 64, 85, 106, 107, 127, 148, 149,
		170, 191, 192, 212, 255};

	function automatic int abs_diff(input int a, input int b);
		return (a > b) ? a - b : b - a;
	endfunction

	// sum of absolute differences between the pixel and a palette entry
	function automatic int palette_distance(input int r, input int g, input int b,
		input int idx);
		int pr, pg, pb, n, step;
		if (idx < BASIC_BRIGHT) begin
			pr = idx[0] ? 'haa : 'h00;
			pg = idx[1] ? 'haa : 'h00;
			pb = idx[2] ? 'haa : 'h00;
		end else if (idx < CUBE_FIRST) begin
			pr = idx[0] ? 'hff : 'h55;
			pg = idx[1] ? 'hff : 'h55;
			pb = idx[2] ? 'hff : 'h55;
		end else if (idx < GREY_FIRST) begin
			n  = idx - CUBE_FIRST;
			pr = (n / 36) * 85 / 2;
			pg = ((n / 6) % 6) * 85 / 2;
			pb = (n % 6) * 85 / 2;
		end else begin
			step = (idx - GREY_FIRST) * 10 + 8;
			pr = step;
			pg = step;
			pb = step;
		end
		return abs_diff(r, pr) + abs_diff(g, pg) + abs_diff(b, pb);
	endfunction

	function automatic int cube_step(input int c);
		int q;
		q = (2 * c + 42) / 85;
		return (q > 5) ? 5 : q;
	endfunction

	// nearest of three candidate entries; later candidates need a strictly lower distance
	function automatic logic [7:0] nearest_palette_index(input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b);
		int peak, hue, pick, pick_dist, cand, cand_dist;
		peak = r;
		if (g > peak) peak = g;
		if (b > peak) peak = b;
		hue = 0;
		if (r > peak / 2) hue = hue | 1;
		if (g > peak / 2) hue = hue | 2;
		if (b > peak / 2) hue = hue | 4;
		if (hue == 7 && peak <= 'h55)
			pick = BASIC_BRIGHT;
		else
			pick = (peak > 'haa) ? (hue | BASIC_BRIGHT) : hue;
		pick_dist = palette_distance(r, g, b, pick);

		cand = CUBE_FIRST + 36 * cube_step(r) + 6 * cube_step(g) + cube_step(b);
		cand_dist = palette_distance(r, g, b, cand);
		if (cand_dist < pick_dist) begin
			pick      = cand;
			pick_dist = cand_dist;
		end

		cand = GREY_FIRST + (int'(r) + int'(g) + int'(b)) / 30;
		if (cand > GREY_LAST)
			cand = GREY_LAST;
		cand_dist = palette_distance(r, g, b, cand);
		if (cand_dist < pick_dist)
			pick = cand;
		return pick[7:0];
	endfunction

	function automatic logic [7:0] to_byte(input int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit, far above the slowest legal run
	initial begin
		#2_000_000;
		$display("** rgb_to_xterm256_quantizer: FAILED **");
		$finish;
	end

	// one pixel transfer; entered and left at a falling edge
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic typed, input logic [7:0] typed_index);
		int gap;
		if (idling && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 3);
			pixel.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.red   <= r;
		pixel.green <= g;
		pixel.blue  <= b;
		do
			@(posedge clk);
		while (!pixel.ready);
		// transfer taken at this edge
		owed_index.push_back(typed ? typed_index : nearest_palette_index(r, g, b));
		pixels_sent++;
		if (int'(r) + int'(g) + int'(b) >= 720)
			clamped_greys++;
		@(negedge clk);
	endtask

	task automatic wait_for_owed_indices();
		while (owed_index.size() != 0)
			@(negedge clk);
	endtask

	// sink side: ready with random stalls while idling is on
	initial begin
		int stall;
		stall = 0;
		colour.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				colour.ready <= 1'b0;
			end else begin
				if (stall == 0 && idling && $urandom_range(0, 5) == 0)
					stall = $urandom_range(1, 3);
				if (stall > 0) begin
					colour.ready <= 1'b0;
					stall--;
				end else begin
					colour.ready <= 1'b1;
				end
			end
		end
	end

	// result checking at the rising edge
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && colour.valid === 1'b1 && colour.ready === 1'b1) begin
			indices_seen++;
			if (colour.palette_index < CUBE_FIRST)
				basic_hits++;
			else if (colour.palette_index < GREY_FIRST)
				cube_hits++;
			else
				grey_hits++;
			if (owed_index.size() == 0) begin
				mismatches++;
				$display("%0t: palette_index expected none, got %0d", $time,
					colour.palette_index);
			end else begin
				want = owed_index.pop_front();
				if (colour.palette_index !== want) begin
					mismatches++;
					$display("%0t: palette_index expected %0d, got %0d", $time, want,
						colour.palette_index);
				end
			end
		end
	end

	// stimulus
	initial begin
		int         i;
		int         k;
		int         base;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;

		arst_n        = 1'b0;
		pixel.valid   = 1'b0;
		pixel.red     = 8'd0;
		pixel.green   = 8'd0;
		pixel.blue    = 8'd0;
		idling        = 1'b0;
		mismatches    = 0;
		pixels_sent   = 0;
		indices_seen  = 0;
		basic_hits    = 0;
		cube_hits     = 0;
		grey_hits     = 0;
		clamped_greys = 0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows, back to back with idling off
		for (i = 0; i < ROW_COUNT; i++)
			send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
				directed_rows[i].typed, directed_rows[i].index);
		pixel.valid <= 1'b0;
		wait_for_owed_indices();

		for (i = 0; i < RANDOM_PIXELS; i++) begin
			// idling on two blocks out of three, none in the tail
			idling = (i < RANDOM_PIXELS - QUIET_TAIL) && ((i / 100) % 3 != 2);

			// hold off once mid-run until the pipeline has emptied
			if (i == RANDOM_PIXELS / 2) begin
				pixel.valid <= 1'b0;
				wait_for_owed_indices();
			end

			case ($urandom_range(0, 9))
				6, 7: begin
					// near-grey, exercises the ramp against the others
					base = $urandom_range(0, 255);
					r = to_byte(base + $urandom_range(0, 16) - 8);
					g = to_byte(base + $urandom_range(0, 16) - 8);
					b = to_byte(base + $urandom_range(0, 16) - 8);
				end
				8: begin
					// around cube level boundaries and colours
					k = $urandom_range(0, 16);
					r = to_byte(cube_anchor[k] + $urandom_range(0, 2) - 1);
					k = $urandom_range(0, 16);
					g = to_byte(cube_anchor[k] + $urandom_range(0, 2) - 1);
					k = $urandom_range(0, 16);
					b = to_byte(cube_anchor[k] + $urandom_range(0, 2) - 1);
				end
				9: begin
					// bright greys, often in the clamped region
					r = 8'($urandom_range(225, 255));
					g = 8'($urandom_range(225, 255));
					b = 8'($urandom_range(225, 255));
				end
				default: begin
					r = 8'($urandom_range(0, 255));
					g = 8'($urandom_range(0, 255));
					b = 8'($urandom_range(0, 255));
				end
			endcase
			send_pixel(r, g, b, 1'b0, 8'd0);
		end
		pixel.valid <= 1'b0;
		idling = 1'b0;

		wait_for_owed_indices();
		// any stray result after the last one is caught by the checker
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d pixels, checked %0d indices (%0d basic, %0d cube, %0d grey).",
			pixels_sent, indices_seen, basic_hits, cube_hits, grey_hits);
		$display("%0d pixels fell in the clamped grey range; %0d mismatches.",
			clamped_greys, mismatches);
		if (mismatches == 0)
			$display("** rgb_to_xterm256_quantizer: PASSED **");
		else
			$display("** rgb_to_xterm256_quantizer: FAILED **");
		$finish;
	end

endmodule
